>>> rtl/blbc_pkg.sv
package blbc_pkg;

    localparam int NUM_BUF = 32;
    localparam int IDX_W   = (NUM_BUF > 1) ? $clog2(NUM_BUF) : 1;
    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int TAG_W   = DEV_W + BLK_W;
    localparam int CNT_W   = 8;
    localparam int SLOT_W  = 5;
    localparam int ST_W    = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUF - 1);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_REL = 1'b1;

    localparam logic [ST_W-1:0] ST_HIT         = 3'd0;
    localparam logic [ST_W-1:0] ST_MISS        = 3'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED   = 3'd2;
    localparam logic [ST_W-1:0] ST_REL_HELD    = 3'd3;
    localparam logic [ST_W-1:0] ST_REL_FREE    = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_RELEASE = 3'd5;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd6;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_ram_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot;
        logic              needs_read;
        logic [CNT_W-1:0]  cnt;
    } t_result;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] rel_idx(input logic [SLOT_W-1:0] rel);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{IDX_W{1'b0}}, rel};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic rel_ok(input logic [SLOT_W-1:0] rel);
        logic [IDX_W+SLOT_W:0] w;
        w = {{(IDX_W+1){1'b0}}, rel};
        return w < (IDX_W+SLOT_W+1)'(NUM_BUF);
    endfunction

endpackage

>>> rtl/blbc_if.sv
interface blbc_req_if;
    import blbc_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] release_slot;

    modport source (output valid, cmd, device, block_number, release_slot, input ready);
    modport sink   (input valid, cmd, device, block_number, release_slot, output ready);
endinterface

interface blbc_rsp_if;
    import blbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic              needs_read;
    logic [CNT_W-1:0]  ref_count;

    modport source (output valid, status, slot, needs_read, ref_count, input ready);
    modport sink   (input valid, status, slot, needs_read, ref_count, output ready);
endinterface

>>> rtl/block_buffer_cache_lru_core.sv
// Channel  Dir  Modport  Word
// i_req    in   sink     cmd, device, block_number, release_slot
// o_rsp    out  source   status, slot, needs_read, ref_count
//
// One word at a time; the tag/count RAM is walked one entry per cycle. A hit
// walks the recency order to the match; a miss walks it all, then from the back
// for a zero count; a release that frees the slot moves it to the recency front;
// the result reaches o_rsp in the same cycle that i_req.ready returns.
// Ready the cycle after reset; i_rst_n is synchronous, active low.
// A stalled o_rsp holds the result and keeps the sequencer in its last state.
module block_buffer_cache_lru_core
    import blbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    blbc_req_if.sink   i_req,
    blbc_rsp_if.source o_rsp
);

    t_ram_req ram_req;
    t_entry   ram_rdata;
    logic     res_vld;
    t_result  res;
    logic     res_take;
    logic     r_out_vld;
    t_result  r_out;

    blbc_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    blbc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_rdata    (ram_rdata),
        .o_ram      (ram_req),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take)
    );

    assign res_take = !r_out_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.slot       = r_out.slot;
    assign o_rsp.needs_read = r_out.needs_read;
    assign o_rsp.ref_count  = r_out.cnt;

endmodule

>>> rtl/blbc_ram.sv
module blbc_ram
    import blbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ram_req i_req,
    output t_entry   o_rdata
);

    t_entry               r_mem [NUM_BUF];
    logic [NUM_BUF-1:0]   r_init;
    t_entry               r_rd;
    logic                 r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // entries never written read as zero tags / zero count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_req.re) begin
                r_rd_init <= r_init[i_req.raddr];
            end
            if (i_req.we) begin
                r_init[i_req.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_init ? r_rd : '0;

endmodule

>>> rtl/blbc_seq.sv
module blbc_seq
    import blbc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    blbc_req_if.sink        i_req,
    input  t_entry          i_rdata,
    output t_ram_req        o_ram,
    output logic            o_res_vld,
    output t_result         o_res,
    input  logic            i_res_take
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_RLCHK = 3'd3;
    localparam logic [2:0] S_MTF   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_iss, n_iss;
    logic              r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]  r_chk_slot, n_chk_slot;
    logic              r_chk_last, n_chk_last;
    logic [DEV_W-1:0]  r_dev, n_dev;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic [SLOT_W-1:0] r_rel, n_rel;
    logic [IDX_W-1:0]  r_carry, n_carry;
    t_result           r_res, n_res;
    logic [IDX_W-1:0]  r_order [NUM_BUF];
    logic [NUM_BUF-1:0] r_valid;

    logic              req_fire;
    logic              valid_set;
    logic              ord_we;
    logic [TAG_W-1:0]  cmp_a, cmp_b;
    logic              cmp_eq;
    logic [IDX_W-1:0]  ord_cur;
    logic [IDX_W-1:0]  mtf_slot;

    assign req_fire  = i_req.valid && i_req.ready;
    assign ord_cur   = r_order[r_pos];
    assign mtf_slot  = rel_idx(r_rel);
    assign cmp_eq    = (cmp_a == cmp_b);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_iss      = r_iss;
        n_chk_vld  = 1'b0;
        n_chk_slot = r_chk_slot;
        n_chk_last = r_chk_last;
        n_dev      = r_dev;
        n_blk      = r_blk;
        n_rel      = r_rel;
        n_carry    = r_carry;
        n_res      = r_res;
        o_ram      = '0;
        valid_set  = 1'b0;
        ord_we     = 1'b0;
        cmp_a      = '0;
        cmp_b      = '0;

        unique case (r_state) inside
            S_IDLE: begin
                if (req_fire) begin
                    n_dev = i_req.device;
                    n_blk = i_req.block_number;
                    n_rel = i_req.release_slot;
                    if (i_req.cmd == CMD_GET) begin
                        n_state = S_FIND;
                        n_pos   = '0;
                        n_iss   = 1'b1;
                    end else begin
                        n_state     = S_RLCHK;
                        o_ram.re    = 1'b1;
                        o_ram.raddr = rel_idx(i_req.release_slot);
                    end
                end
            end
            S_FIND, S_FREE: begin
                if (r_state == S_FIND) begin
                    cmp_a = {i_rdata.dev, i_rdata.blk};
                    cmp_b = {r_dev, r_blk};
                end else begin
                    cmp_a = TAG_W'(i_rdata.cnt);
                    cmp_b = '0;
                end
                // issue next read, one recency position per cycle
                if (r_iss) begin
                    o_ram.re   = 1'b1;
                    o_ram.raddr = ord_cur;
                    n_chk_vld  = 1'b1;
                    n_chk_slot = ord_cur;
                    n_chk_last = (r_state == S_FIND) ? (r_pos == IDX_LAST) : (r_pos == '0);
                    if (n_chk_last) begin
                        n_iss = 1'b0;
                    end else if (r_state == S_FIND) begin
                        n_pos = r_pos + 1'b1;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
                // check data read last cycle
                if (r_chk_vld) begin
                    if (cmp_eq) begin
                        n_chk_vld = 1'b0;
                        n_iss     = 1'b0;
                        n_state   = S_DONE;
                        if (r_state == S_FIND) begin
                            if (i_rdata.cnt == CNT_MAX) begin
                                n_res = '{ST_OVERFLOW, to_slot(r_chk_slot), 1'b0, CNT_MAX};
                            end else begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = r_chk_slot;
                                o_ram.wdata = '{r_dev, r_blk, i_rdata.cnt + 1'b1};
                                valid_set   = 1'b1;
                                n_res = '{ST_HIT, to_slot(r_chk_slot), !r_valid[r_chk_slot],
                                          i_rdata.cnt + 1'b1};
                            end
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_chk_slot;
                            o_ram.wdata = '{r_dev, r_blk, CNT_W'(1)};
                            valid_set   = 1'b1;
                            n_res = '{ST_MISS, to_slot(r_chk_slot), 1'b1, CNT_W'(1)};
                        end
                    end else if (r_chk_last) begin
                        n_chk_vld = 1'b0;
                        if (r_state == S_FIND) begin
                            n_state = S_FREE;
                            n_pos   = IDX_LAST;
                            n_iss   = 1'b1;
                        end else begin
                            n_state = S_DONE;
                            n_res   = '{ST_EXHAUSTED, '0, 1'b0, '0};
                        end
                    end
                end
            end
            S_RLCHK: begin
                cmp_a = TAG_W'(i_rdata.cnt);
                cmp_b = '0;
                if (!rel_ok(r_rel) || cmp_eq) begin
                    n_state = S_DONE;
                    n_res   = '{ST_BAD_RELEASE, r_rel, 1'b0, '0};
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = mtf_slot;
                    o_ram.wdata = '{i_rdata.dev, i_rdata.blk, i_rdata.cnt - 1'b1};
                    if (i_rdata.cnt == CNT_W'(1)) begin
                        n_state = S_MTF;
                        n_pos   = '0;
                        n_carry = mtf_slot;
                    end else begin
                        n_state = S_DONE;
                        n_res   = '{ST_REL_HELD, r_rel, 1'b0, i_rdata.cnt - 1'b1};
                    end
                end
            end
            S_MTF: begin
                // bubble the freed slot to the front, one position per cycle
                cmp_a   = TAG_W'(ord_cur);
                cmp_b   = TAG_W'(mtf_slot);
                ord_we  = 1'b1;
                n_carry = ord_cur;
                if (cmp_eq) begin
                    n_state = S_DONE;
                    n_res   = '{ST_REL_FREE, r_rel, 1'b0, '0};
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss     <= 1'b0;
            r_chk_vld <= 1'b0;
            r_valid   <= '0;
            for (int i = 0; i < NUM_BUF; i++) begin
                r_order[i] <= IDX_W'(i);
            end
        end else begin
            r_state   <= n_state;
            r_iss     <= n_iss;
            r_chk_vld <= n_chk_vld;
            if (valid_set) begin
                r_valid[r_chk_slot] <= 1'b1;
            end
            if (ord_we) begin
                r_order[r_pos] <= r_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_chk_slot <= n_chk_slot;
        r_chk_last <= n_chk_last;
        r_dev      <= n_dev;
        r_blk      <= n_blk;
        r_rel      <= n_rel;
        r_carry    <= n_carry;
        r_res      <= n_res;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_vld   = (r_state == S_DONE);
    assign o_res       = r_res;

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == S_FIND || r_state == S_FREE || r_state == S_RLCHK))
        else $error("table write outside a lookup or release");

    a_mtf_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MTF && r_pos == IDX_LAST) |-> (ord_cur == mtf_slot))
        else $error("freed slot missing from recency order");

    a_claim_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE && o_ram.we) |-> (o_ram.wdata.cnt == CNT_W'(1)))
        else $error("claimed slot count not one");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != S_IDLE))
        else $error("sequencer did not leave idle on accept");

endmodule

>>> tb/blbc_cache_checker.sv
module blbc_cache_checker
    import blbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    blbc_req_if  i_req,
    blbc_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_pending
);

    logic [IDX_W-1:0] lru_order [NUM_BUF];
    logic [DEV_W-1:0] dev_tag   [NUM_BUF];
    logic [BLK_W-1:0] blk_tag   [NUM_BUF];
    logic [CNT_W-1:0] ref_cnt   [NUM_BUF];
    logic             loaded    [NUM_BUF];

    t_result expected_rsp_q [$];
    int      mismatch_count = 0;
    int      word_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on word %0d, %s: got %0h, expected %0h",
                 word_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_result predict_cache_step(input logic cmd,
                                                   input logic [DEV_W-1:0] dev,
                                                   input logic [BLK_W-1:0] blk,
                                                   input logic [SLOT_W-1:0] rel);
        t_result r;
        logic    found;
        int      s;
        int      idx;
        int      pos;
        r = '0;
        found = 1'b0;
        s = 0;
        pos = 0;
        if (cmd == CMD_GET) begin
            // search from most recent
            for (int i = 0; i < NUM_BUF; i++) begin
                if (!found && dev_tag[lru_order[i]] == dev && blk_tag[lru_order[i]] == blk) begin
                    found = 1'b1;
                    s = int'(lru_order[i]);
                end
            end
            if (found) begin
                if (ref_cnt[s] == CNT_MAX) begin
                    r.status = ST_OVERFLOW;
                    r.slot   = SLOT_W'(s);
                    r.cnt    = CNT_MAX;
                end else begin
                    ref_cnt[s]   = ref_cnt[s] + 1'b1;
                    r.needs_read = !loaded[s];
                    loaded[s]    = 1'b1;
                    r.status     = ST_HIT;
                    r.slot       = SLOT_W'(s);
                    r.cnt        = ref_cnt[s];
                end
            end else begin
                // victim: least recent slot with no references
                for (int i = NUM_BUF - 1; i >= 0; i--) begin
                    if (!found && ref_cnt[lru_order[i]] == '0) begin
                        found = 1'b1;
                        s = int'(lru_order[i]);
                    end
                end
                if (found) begin
                    ref_cnt[s]   = CNT_W'(1);
                    dev_tag[s]   = dev;
                    blk_tag[s]   = blk;
                    loaded[s]    = 1'b1;
                    r.status     = ST_MISS;
                    r.slot       = SLOT_W'(s);
                    r.needs_read = 1'b1;
                    r.cnt        = CNT_W'(1);
                end else begin
                    r.status = ST_EXHAUSTED;
                end
            end
        end else begin
            idx = int'(rel);
            if (idx >= NUM_BUF || ref_cnt[idx] == '0) begin
                r.status = ST_BAD_RELEASE;
                r.slot   = rel;
            end else begin
                ref_cnt[idx] = ref_cnt[idx] - 1'b1;
                r.slot = rel;
                if (ref_cnt[idx] == '0) begin
                    for (int i = 0; i < NUM_BUF; i++) begin
                        if (int'(lru_order[i]) == idx && pos == 0) pos = i;
                    end
                    for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
                    lru_order[0] = IDX_W'(idx);
                    r.status = ST_REL_FREE;
                end else begin
                    r.status = ST_REL_HELD;
                    r.cnt    = ref_cnt[idx];
                end
            end
        end
        return r;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result got_word;
        t_result want_word;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUF; i++) begin
                lru_order[i] = IDX_W'(i);
                dev_tag[i]   = '0;
                blk_tag[i]   = '0;
                ref_cnt[i]   = '0;
                loaded[i]    = 1'b0;
            end
            expected_rsp_q.delete();
        end else begin
            // response first: it belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                got_word.status     = i_rsp.status;
                got_word.slot       = i_rsp.slot;
                got_word.needs_read = i_rsp.needs_read;
                got_word.cnt        = i_rsp.ref_count;
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("unexpected word, status", 32'(got_word.status), '0);
                end else begin
                    want_word = expected_rsp_q.pop_front();
                    if (got_word.status !== want_word.status)
                        report_mismatch("status", 32'(got_word.status), 32'(want_word.status));
                    if (got_word.slot !== want_word.slot)
                        report_mismatch("slot", 32'(got_word.slot), 32'(want_word.slot));
                    if (got_word.needs_read !== want_word.needs_read)
                        report_mismatch("needs_read", 32'(got_word.needs_read),
                                        32'(want_word.needs_read));
                    if (got_word.cnt !== want_word.cnt)
                        report_mismatch("ref_count", 32'(got_word.cnt), 32'(want_word.cnt));
                end
                word_count++;
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.push_back(predict_cache_step(i_req.cmd, i_req.device,
                                                            i_req.block_number,
                                                            i_req.release_slot));
            end
        end
        o_pending    <= expected_rsp_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> tb/block_buffer_cache_lru_core_tb.sv
module block_buffer_cache_lru_core_tb;
    import blbc_pkg::*;

    localparam int RUN_LIMIT   = 600000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_WORDS = 25;
    localparam int POOL_SIZE   = 40;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   mismatches;
    int   pending;
    int   stall_left;
    int   held_refs [NUM_BUF];

    logic [DEV_W-1:0] pool_dev [POOL_SIZE];
    logic [BLK_W-1:0] pool_blk [POOL_SIZE];

    blbc_req_if req_if();
    blbc_rsp_if rsp_if();

    block_buffer_cache_lru_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    blbc_cache_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // response side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                stall_left = calm ? 0 : $urandom_range(0, 6);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            rsp_if.ready <= (stall_left == 0);
        end
    end

    // references currently held, used to aim releases
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            case (rsp_if.status)
                ST_HIT, ST_MISS: begin
                    held_refs[rsp_if.slot]++;
                end
                ST_REL_HELD, ST_REL_FREE: begin
                    held_refs[rsp_if.slot]--;
                end
                default: begin
                end
            endcase
        end
    end

    task automatic send_word(input logic cmd, input logic [DEV_W-1:0] dev,
                             input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] rel);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.cmd          <= cmd;
        req_if.device       <= dev;
        req_if.block_number <= blk;
        req_if.release_slot <= rel;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic send_get(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
        send_word(CMD_GET, dev, blk, SLOT_W'($urandom));
    endtask

    task automatic send_release(input logic [SLOT_W-1:0] rel);
        send_word(CMD_REL, DEV_W'($urandom), BLK_W'($urandom), rel);
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic release_all_held();
        int n;
        wait_for_results();
        for (int s = 0; s < NUM_BUF; s++) begin
            n = held_refs[s];
            repeat (n) send_release(SLOT_W'(s));
        end
        wait_for_results();
    endtask

    initial begin
        int               gets_pct;
        int               start;
        int               k;
        logic             got_one;
        logic [SLOT_W-1:0] rel;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;

        i_rst_n             = 1'b0;
        calm                = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_GET;
        req_if.device       = '0;
        req_if.block_number = '0;
        req_if.release_slot = '0;
        rsp_if.ready        = 1'b0;
        for (int i = 0; i < NUM_BUF; i++) held_refs[i] = 0;
        // the first eight tags share a device; every fifth tag has block number i
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_dev[i] = (i < 8) ? DEV_W'(7) : DEV_W'($urandom);
            pool_blk[i] = (i % 5 == 0) ? BLK_W'(i) : BLK_W'($urandom);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tags are zero: first get hits slot 0 before it is valid
        send_get('0, '0);
        send_get('0, '0);
        send_get(8'hFF, 32'hFFFF_FFFF);
        send_get(8'hAA, 32'h5555_5555);
        send_get(8'h55, 32'hAAAA_AAAA);
        send_get(8'hFF, 32'hFFFF_FFFF);
        send_release(5'd0);
        send_release(5'd0);
        send_release(5'd0);
        send_release(5'd31);
        send_release(5'd31);
        send_release(5'd31);
        send_release(5'd17);
        send_release(5'd30);
        send_release(5'd29);
        send_get('0, '0);
        send_release(5'd0);
        send_get(8'hFF, 32'hFFFF_FFFF);
        send_release(5'd31);
        wait_for_results();

        // fill every slot, then one more miss runs out of buffers
        for (int i = 0; i <= NUM_BUF; i++) send_get(8'h10, 32'h8000_0000 | i);
        send_get(8'h10, 32'h8000_0000);
        release_all_held();

        // count saturation on one tag
        calm = 1'b1;
        dev = DEV_W'($urandom);
        blk = BLK_W'($urandom);
        repeat (257) send_get(dev, blk);
        release_all_held();
        calm = 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       gets_pct = 80;
                1:       gets_pct = 55;
                2:       gets_pct = 30;
                3:       gets_pct = 85;
                4:       gets_pct = 60;
                default: gets_pct = 40;
            endcase
            calm = (ph == 3);
            repeat (PHASE_WORDS) begin
                if ($urandom_range(0, 99) < gets_pct) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_get(DEV_W'($urandom), BLK_W'($urandom));
                    end else begin
                        k = $urandom_range(0, POOL_SIZE - 1);
                        send_get(pool_dev[k], pool_blk[k]);
                    end
                end else begin
                    rel = SLOT_W'($urandom);
                    if ($urandom_range(0, 4) != 0) begin
                        start = $urandom_range(0, NUM_BUF - 1);
                        got_one = 1'b0;
                        for (int j = 0; j < NUM_BUF; j++) begin
                            if (!got_one && held_refs[(start + j) % NUM_BUF] > 0) begin
                                rel = SLOT_W'((start + j) % NUM_BUF);
                                got_one = 1'b1;
                            end
                        end
                    end
                    send_release(rel);
                end
            end
            wait_for_results();
        end
        calm = 1'b0;

        wait_for_results();
        repeat (2 * NUM_BUF + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
